/* sv/coc_pkg.sv */
// Shared types and constants for the cursor overlay compositor.
`timescale 1ns / 1ps

package coc_pkg;

   localparam int unsigned PIX_W  = 12;
   localparam int unsigned POS_W  = 13;
   localparam int unsigned DIM_W  = 7;
   localparam int unsigned SURF_W = 13;
   localparam int unsigned LIM_W  = 14;
   localparam int unsigned ARGB_W = 32;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 13;

   localparam logic [DIM_W-1:0]  MAX_CURSOR_DIM  = 7'd64;
   localparam logic [SURF_W-1:0] MAX_SURFACE_DIM = 13'd4096;

   localparam logic [DIM_W-1:0]  RST_CURSOR_W  = 7'd32;
   localparam logic [DIM_W-1:0]  RST_CURSOR_H  = 7'd32;
   localparam logic [SURF_W-1:0] RST_SURFACE_W = 13'd1024;
   localparam logic [SURF_W-1:0] RST_SURFACE_H = 13'd768;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CURSOR_X   = 3'd0,
      REG_CURSOR_Y   = 3'd1,
      REG_CURSOR_W   = 3'd2,
      REG_CURSOR_H   = 3'd3,
      REG_SURFACE_W  = 3'd4,
      REG_SURFACE_H  = 3'd5,
      REG_MODE       = 3'd6,
      REG_VISIBLE    = 3'd7
   } coc_reg_type;

   typedef enum logic [1:0] {
      MODE_MONO     = 2'd0,
      MODE_ALPHA    = 2'd1,
      MODE_MASKED   = 2'd2,
      MODE_RESERVED = 2'd3
   } coc_mode_type;

   // clipped rectangle limits: lo inclusive, hi exclusive
   typedef struct packed {
      logic signed [LIM_W-1:0] lo_x;
      logic signed [LIM_W-1:0] hi_x;
      logic signed [LIM_W-1:0] lo_y;
      logic signed [LIM_W-1:0] hi_y;
      coc_mode_type            mode;
      logic                    visible;
   } coc_cfg_type;

endpackage

/* sv/cursor_overlay_compositor.sv */
// Top level of the hardware cursor overlay compositor.
// Takes one surface pixel per clock and returns it with the cursor composited in:
// monochrome AND/XOR masks, per-channel alpha blend, or masked colour, surface
// alpha kept in the colour modes; the reserved mode passes it unchanged.
// Throughput is one item per cycle while the result side is not stalled. An
// accepted item passes through three pipeline registers before rsp_tvalid rises:
// rectangle test and channel differences, alpha products, and divide by 255 with
// mode select. Back-pressure on the result side stalls all stages in place.
// Registers must be written through the csr_ port only while no item is in flight;
// the block itself does not enforce this. csr_ready is always high.
`timescale 1ns / 1ps

module cursor_overlay_compositor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pixel_x[11:0], pixel_y[23:12], surface_pixel[55:24], cursor_argb[87:56],
   // and_bit[88], xor_bit[89], zero[95:90]
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_pixel[31:0], cursor_hit[32], zero[39:33]
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_data
);

   coc_pkg::coc_cfg_type cfg;
   logic [31:0]          out_pixel;
   logic                 cursor_hit;

   coc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   coc_pipe u_pipe (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .pixel_x       (req_tdata[11:0]),
      .pixel_y       (req_tdata[23:12]),
      .surface_pixel (req_tdata[55:24]),
      .cursor_argb   (req_tdata[87:56]),
      .and_bit       (req_tdata[88]),
      .xor_bit       (req_tdata[89]),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_pixel     (out_pixel),
      .cursor_hit    (cursor_hit)
   );

   assign rsp_tdata = {7'd0, cursor_hit, out_pixel};

endmodule

/* sv/coc_csr.sv */
// Register file and clipped cursor rectangle limits.
`timescale 1ns / 1ps

module coc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [coc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [coc_pkg::CSR_DATA_W-1:0]      csr_data,
   output coc_pkg::coc_cfg_type                cfg
);

   logic signed [coc_pkg::POS_W-1:0]  cursor_x_ff;
   logic signed [coc_pkg::POS_W-1:0]  cursor_y_ff;
   logic [coc_pkg::DIM_W-1:0]         cursor_w_ff;
   logic [coc_pkg::DIM_W-1:0]         cursor_h_ff;
   logic [coc_pkg::SURF_W-1:0]        surface_w_ff;
   logic [coc_pkg::SURF_W-1:0]        surface_h_ff;
   coc_pkg::coc_mode_type             mode_ff;
   logic                              visible_ff;

   logic [coc_pkg::DIM_W-1:0]         len_x;
   logic [coc_pkg::DIM_W-1:0]         len_y;
   logic [coc_pkg::SURF_W-1:0]        sat_w;
   logic [coc_pkg::SURF_W-1:0]        sat_h;
   logic signed [coc_pkg::LIM_W-1:0]  end_x;
   logic signed [coc_pkg::LIM_W-1:0]  end_y;
   logic signed [coc_pkg::LIM_W-1:0]  edge_x;
   logic signed [coc_pkg::LIM_W-1:0]  edge_y;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         cursor_w_ff  <= coc_pkg::RST_CURSOR_W;
         cursor_h_ff  <= coc_pkg::RST_CURSOR_H;
         surface_w_ff <= coc_pkg::RST_SURFACE_W;
         surface_h_ff <= coc_pkg::RST_SURFACE_H;
         mode_ff      <= coc_pkg::MODE_MONO;
         visible_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (coc_pkg::coc_reg_type'(csr_index))
            coc_pkg::REG_CURSOR_X:  cursor_x_ff  <= $signed(csr_data);
            coc_pkg::REG_CURSOR_Y:  cursor_y_ff  <= $signed(csr_data);
            coc_pkg::REG_CURSOR_W:  cursor_w_ff  <= csr_data[coc_pkg::DIM_W-1:0];
            coc_pkg::REG_CURSOR_H:  cursor_h_ff  <= csr_data[coc_pkg::DIM_W-1:0];
            coc_pkg::REG_SURFACE_W: surface_w_ff <= csr_data;
            coc_pkg::REG_SURFACE_H: surface_h_ff <= csr_data;
            coc_pkg::REG_MODE:      mode_ff      <= coc_pkg::coc_mode_type'(csr_data[1:0]);
            coc_pkg::REG_VISIBLE:   visible_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      len_x = (cursor_w_ff > coc_pkg::MAX_CURSOR_DIM) ? coc_pkg::MAX_CURSOR_DIM : cursor_w_ff;
      len_y = (cursor_h_ff > coc_pkg::MAX_CURSOR_DIM) ? coc_pkg::MAX_CURSOR_DIM : cursor_h_ff;
      sat_w = (surface_w_ff > coc_pkg::MAX_SURFACE_DIM) ? coc_pkg::MAX_SURFACE_DIM
                                                         : surface_w_ff;
      sat_h = (surface_h_ff > coc_pkg::MAX_SURFACE_DIM) ? coc_pkg::MAX_SURFACE_DIM
                                                         : surface_h_ff;

      end_x  = $signed({cursor_x_ff[coc_pkg::POS_W-1], cursor_x_ff})
             + $signed({7'd0, len_x});
      end_y  = $signed({cursor_y_ff[coc_pkg::POS_W-1], cursor_y_ff})
             + $signed({7'd0, len_y});
      edge_x = $signed({1'b0, sat_w}) - 14'sd1;
      edge_y = $signed({1'b0, sat_h}) - 14'sd1;

      cfg.lo_x    = cursor_x_ff[coc_pkg::POS_W-1] ? '0 : $signed({1'b0, cursor_x_ff});
      cfg.lo_y    = cursor_y_ff[coc_pkg::POS_W-1] ? '0 : $signed({1'b0, cursor_y_ff});
      cfg.hi_x    = (end_x < edge_x) ? end_x : edge_x;
      cfg.hi_y    = (end_y < edge_y) ? end_y : edge_y;
      cfg.mode    = mode_ff;
      cfg.visible = visible_ff;
   end

endmodule

/* sv/coc_pipe.sv */
// Three-stage compositing pipeline: hit test and differences, products, divide and select.
`timescale 1ns / 1ps

module coc_pipe (
   input  logic                               clock,
   input  logic                               reset,
   input  coc_pkg::coc_cfg_type               cfg,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [coc_pkg::PIX_W-1:0]          pixel_x,
   input  logic [coc_pkg::PIX_W-1:0]          pixel_y,
   input  logic [coc_pkg::ARGB_W-1:0]         surface_pixel,
   input  logic [coc_pkg::ARGB_W-1:0]         cursor_argb,
   input  logic                               and_bit,
   input  logic                               xor_bit,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [coc_pkg::ARGB_W-1:0]         out_pixel,
   output logic                               cursor_hit
);

   // stage 1
   logic                          v1_ff;
   logic [31:0]                   surf1_ff;
   logic [31:0]                   cur1_ff;
   logic                          and1_ff;
   logic                          xor1_ff;
   logic                          hit1_ff;
   coc_pkg::coc_mode_type         mode1_ff;
   logic [2:0][7:0]               mag1_ff;
   logic [2:0]                    neg1_ff;
   logic                          hit1_in;
   logic [2:0][7:0]               mag1_in;
   logic [2:0]                    neg1_in;
   logic signed [coc_pkg::LIM_W-1:0] sx;
   logic signed [coc_pkg::LIM_W-1:0] sy;

   // stage 2
   logic                          v2_ff;
   logic [31:0]                   surf2_ff;
   logic [31:0]                   cur2_ff;
   logic                          and2_ff;
   logic                          xor2_ff;
   logic                          hit2_ff;
   coc_pkg::coc_mode_type         mode2_ff;
   logic [2:0][15:0]              prod2_ff;
   logic [2:0]                    neg2_ff;
   logic [2:0][15:0]              prod2_in;

   // stage 3
   logic                          v3_ff;
   logic [31:0]                   pix3_ff;
   logic                          hit3_ff;
   logic [31:0]                   pix3_in;
   logic [2:0][15:0]              qsum;
   logic [2:0][7:0]               chan;
   logic [23:0]                   rgb;

   logic                          rdy1;
   logic                          rdy2;
   logic                          rdy3;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      sx      = $signed({2'b00, pixel_x});
      sy      = $signed({2'b00, pixel_y});
      hit1_in = cfg.visible && (sx >= cfg.lo_x) && (sx < cfg.hi_x)
                            && (sy >= cfg.lo_y) && (sy < cfg.hi_y);
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = cursor_argb[8*i +: 8] < surface_pixel[8*i +: 8];
         mag1_in[i] = neg1_in[i] ? (surface_pixel[8*i +: 8] - cursor_argb[8*i +: 8])
                                 : (cursor_argb[8*i +: 8] - surface_pixel[8*i +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= in_valid;
      end
      if (rdy1 && in_valid) begin
         surf1_ff <= surface_pixel;
         cur1_ff  <= cursor_argb;
         and1_ff  <= and_bit;
         xor1_ff  <= xor_bit;
         hit1_ff  <= hit1_in;
         mode1_ff <= cfg.mode;
         mag1_ff  <= mag1_in;
         neg1_ff  <= neg1_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod2_in[i] = 16'(mag1_ff[i] * cur1_ff[31:24]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
      if (rdy2 && v1_ff) begin
         surf2_ff <= surf1_ff;
         cur2_ff  <= cur1_ff;
         and2_ff  <= and1_ff;
         xor2_ff  <= xor1_ff;
         hit2_ff  <= hit1_ff;
         mode2_ff <= mode1_ff;
         prod2_ff <= prod2_in;
         neg2_ff  <= neg1_ff;
      end
   end

   // x / 255 as (x + 1 + (x >> 8)) >> 8, exact below 255 * 256
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qsum[i] = prod2_ff[i] + 16'd1 + {8'd0, prod2_ff[i][15:8]};
         chan[i] = neg2_ff[i] ? (surf2_ff[8*i +: 8] - qsum[i][15:8])
                              : (surf2_ff[8*i +: 8] + qsum[i][15:8]);
      end
      rgb     = (cur2_ff[31:24] == 8'd0) ? cur2_ff[23:0] : (surf2_ff[23:0] ^ cur2_ff[23:0]);
      pix3_in = surf2_ff;
      if (hit2_ff) begin
         case (mode2_ff)
            coc_pkg::MODE_MONO:   pix3_in = (and2_ff ? surf2_ff : 32'd0) ^ {32{xor2_ff}};
            coc_pkg::MODE_ALPHA:  pix3_in = {surf2_ff[31:24], chan[2], chan[1], chan[0]};
            coc_pkg::MODE_MASKED: pix3_in = {surf2_ff[31:24], rgb};
            default:              pix3_in = surf2_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
      if (rdy3 && v2_ff) begin
         pix3_ff <= pix3_in;
         hit3_ff <= hit2_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign out_pixel  = pix3_ff;
   assign cursor_hit = hit3_ff;

endmodule

/* sv/coc_checker.sv */
// Port-level checks for the cursor overlay compositor, bound to the top level.
`timescale 1ns / 1ps

module coc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("item not delivered after three free-running cycles");

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output side is ready");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind cursor_overlay_compositor coc_checker u_coc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/sv/cursor_overlay_compositor_tb.sv */
// Self-checking testbench for the cursor overlay compositor: directed corners, then random pixels.
`timescale 1ns / 1ps

module cursor_overlay_compositor_tb;

   localparam int LATENCY        = 3;
   localparam int STALL_PCT      = 38;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic                       xor_bit;
      logic                       and_bit;
      logic [31:0]                cursor_argb;
      logic [31:0]                surface_pixel;
      logic [coc_pkg::PIX_W-1:0]  pixel_y;
      logic [coc_pkg::PIX_W-1:0]  pixel_x;
   } pixel_item_type;

   typedef struct packed {
      logic        cursor_hit;
      logic [31:0] out_pixel;
   } composite_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [12:0] csr_data = '0;

   // register copy, reset values
   logic signed [coc_pkg::POS_W-1:0] m_cursor_x  = '0;
   logic signed [coc_pkg::POS_W-1:0] m_cursor_y  = '0;
   logic [coc_pkg::DIM_W-1:0]        m_cursor_w  = coc_pkg::RST_CURSOR_W;
   logic [coc_pkg::DIM_W-1:0]        m_cursor_h  = coc_pkg::RST_CURSOR_H;
   logic [coc_pkg::SURF_W-1:0]       m_surface_w = coc_pkg::RST_SURFACE_W;
   logic [coc_pkg::SURF_W-1:0]       m_surface_h = coc_pkg::RST_SURFACE_H;
   coc_pkg::coc_mode_type            m_mode      = coc_pkg::MODE_MONO;
   logic                             m_visible   = 1'b0;

   composite_type pending_pixels[$];
   bit full_rate = 1'b0;
   int n_items = 0;
   int n_hits = 0;
   int n_results = 0;
   int n_mismatches = 0;
   int n_settings = 0;
   int idle_cycles = 0;

   cursor_overlay_compositor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int span_lo(int pos);
      return pos < 0 ? 0 : pos;
   endfunction

   // exclusive limit; stops short of the last surface column or row
   function automatic int span_hi(int pos, int len, int surf);
      int l;
      int s;
      l = len > int'(coc_pkg::MAX_CURSOR_DIM) ? int'(coc_pkg::MAX_CURSOR_DIM) : len;
      s = surf > int'(coc_pkg::MAX_SURFACE_DIM) ? int'(coc_pkg::MAX_SURFACE_DIM) : surf;
      return (pos + l) < (s - 1) ? (pos + l) : (s - 1);
   endfunction

   function automatic logic [7:0] blend_channel(int s, int c, int a);
      int d;
      d = (c - s) * a;
      return 8'(s + d / 255);
   endfunction

   function automatic composite_type composite_pixel(pixel_item_type it);
      composite_type r;
      int px;
      int py;
      int ca;
      logic [23:0] rgb;
      px = int'(it.pixel_x);
      py = int'(it.pixel_y);
      ca = int'(it.cursor_argb[31:24]);
      r.out_pixel = it.surface_pixel;
      r.cursor_hit = m_visible
         && px >= span_lo(int'(m_cursor_x))
         && px < span_hi(int'(m_cursor_x), int'(m_cursor_w), int'(m_surface_w))
         && py >= span_lo(int'(m_cursor_y))
         && py < span_hi(int'(m_cursor_y), int'(m_cursor_h), int'(m_surface_h));
      if (r.cursor_hit) begin
         case (m_mode)
            coc_pkg::MODE_MONO: begin
               r.out_pixel = it.and_bit ? it.surface_pixel : 32'h0;
               if (it.xor_bit) r.out_pixel = ~r.out_pixel;
            end
            coc_pkg::MODE_ALPHA: begin
               r.out_pixel = {it.surface_pixel[31:24],
                  blend_channel(int'(it.surface_pixel[23:16]),
                                int'(it.cursor_argb[23:16]), ca),
                  blend_channel(int'(it.surface_pixel[15:8]),
                                int'(it.cursor_argb[15:8]), ca),
                  blend_channel(int'(it.surface_pixel[7:0]),
                                int'(it.cursor_argb[7:0]), ca)};
            end
            coc_pkg::MODE_MASKED: begin
               rgb = (ca == 0) ? it.cursor_argb[23:0]
                               : it.surface_pixel[23:0] ^ it.cursor_argb[23:0];
               r.out_pixel = {it.surface_pixel[31:24], rgb};
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   // all driving tasks start and end just after a falling edge, with req_tvalid low
   task automatic settle_pipeline();
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (LATENCY + 1) @(negedge clock);
   endtask

   task automatic write_reg(coc_pkg::coc_reg_type idx,
                            logic [coc_pkg::CSR_DATA_W-1:0] val);
      settle_pipeline();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         coc_pkg::REG_CURSOR_X:  m_cursor_x  = val;
         coc_pkg::REG_CURSOR_Y:  m_cursor_y  = val;
         coc_pkg::REG_CURSOR_W:  m_cursor_w  = val[coc_pkg::DIM_W-1:0];
         coc_pkg::REG_CURSOR_H:  m_cursor_h  = val[coc_pkg::DIM_W-1:0];
         coc_pkg::REG_SURFACE_W: m_surface_w = val;
         coc_pkg::REG_SURFACE_H: m_surface_h = val;
         coc_pkg::REG_MODE:      m_mode      = coc_pkg::coc_mode_type'(val[1:0]);
         coc_pkg::REG_VISIBLE:   m_visible   = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(int x, int y, int w, int h, int sw, int sh,
                            coc_pkg::coc_mode_type mode, bit vis);
      write_reg(coc_pkg::REG_CURSOR_X, coc_pkg::CSR_DATA_W'(x));
      write_reg(coc_pkg::REG_CURSOR_Y, coc_pkg::CSR_DATA_W'(y));
      write_reg(coc_pkg::REG_CURSOR_W, coc_pkg::CSR_DATA_W'(w));
      write_reg(coc_pkg::REG_CURSOR_H, coc_pkg::CSR_DATA_W'(h));
      write_reg(coc_pkg::REG_SURFACE_W, coc_pkg::CSR_DATA_W'(sw));
      write_reg(coc_pkg::REG_SURFACE_H, coc_pkg::CSR_DATA_W'(sh));
      write_reg(coc_pkg::REG_MODE, coc_pkg::CSR_DATA_W'(mode));
      write_reg(coc_pkg::REG_VISIBLE, coc_pkg::CSR_DATA_W'(vis));
      n_settings++;
   endtask

   task automatic send_pixel(logic [coc_pkg::PIX_W-1:0] px, logic [coc_pkg::PIX_W-1:0] py,
                             logic [31:0] surf, logic [31:0] cur, logic andb, logic xorb);
      pixel_item_type it;
      composite_type want;
      it = '{xor_bit: xorb, and_bit: andb, cursor_argb: cur, surface_pixel: surf,
             pixel_y: py, pixel_x: px};
      while (!full_rate && $urandom_range(99) < STALL_PCT) @(negedge clock);
      req_tdata  = {6'd0, it};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      want = composite_pixel(it);
      pending_pixels.push_back(want);
      n_items++;
      if (want.cursor_hit) n_hits++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   always @(negedge clock)
      rsp_tready <= full_rate || ($urandom_range(99) >= STALL_PCT);

   always @(posedge clock) begin : check_results
      composite_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            n_mismatches++;
            $display("%0t: unexpected item: expected none, actual pixel %h hit %b",
                     $time, rsp_tdata[31:0], rsp_tdata[32]);
         end else begin
            want = pending_pixels.pop_front();
            n_results++;
            if (rsp_tdata[31:0] !== want.out_pixel) begin
               n_mismatches++;
               $display("%0t: out_pixel mismatch: expected %h, actual %h",
                        $time, want.out_pixel, rsp_tdata[31:0]);
            end
            if (rsp_tdata[32] !== want.cursor_hit) begin
               n_mismatches++;
               $display("%0t: cursor_hit mismatch: expected %b, actual %b",
                        $time, want.cursor_hit, rsp_tdata[32]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no handshake for %0d cycles, %0d items outstanding",
                  $time, idle_cycles, pending_pixels.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic test_reset_pass_through();
      // cursor hidden after reset
      send_pixel(12'd0, 12'd0, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0, 1'b1);
      send_pixel(12'd10, 12'd10, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
   endtask

   task automatic test_monochrome();
      write_reg(coc_pkg::REG_VISIBLE, coc_pkg::CSR_DATA_W'(1));
      send_pixel(12'd3, 12'd4, 32'hA5C3_0F96, 32'h0, 1'b0, 1'b0);
      send_pixel(12'd3, 12'd4, 32'hA5C3_0F96, 32'h0, 1'b1, 1'b0);
      send_pixel(12'd3, 12'd4, 32'hA5C3_0F96, 32'h0, 1'b0, 1'b1);
      send_pixel(12'd3, 12'd4, 32'hA5C3_0F96, 32'h0, 1'b1, 1'b1);
      send_pixel(12'd31, 12'd31, 32'h0000_0000, 32'h0, 1'b1, 1'b1);
      send_pixel(12'd32, 12'd5, 32'h0000_0000, 32'h0, 1'b0, 1'b1);
   endtask

   task automatic test_alpha_blend();
      write_reg(coc_pkg::REG_MODE, coc_pkg::CSR_DATA_W'(coc_pkg::MODE_ALPHA));
      send_pixel(12'd1, 12'd1, 32'h7F10_2030, 32'h00FF_FFFF, 1'b0, 1'b0);
      send_pixel(12'd1, 12'd1, 32'h7F10_2030, 32'hFF0A_0B0C, 1'b1, 1'b1);
      // one channel rises, one falls, one stays
      send_pixel(12'd2, 12'd2, 32'h4020_F0C0, 32'h80FF_00C0, 1'b0, 1'b1);
   endtask

   task automatic test_masked_colour();
      write_reg(coc_pkg::REG_MODE, coc_pkg::CSR_DATA_W'(coc_pkg::MODE_MASKED));
      send_pixel(12'd1, 12'd2, 32'hC311_2233, 32'h00AB_CDEF, 1'b0, 1'b0);
      send_pixel(12'd1, 12'd2, 32'hC311_2233, 32'h01AB_CDEF, 1'b0, 1'b0);
      send_pixel(12'd1, 12'd2, 32'hC311_2233, 32'hFFFF_FFFF, 1'b1, 1'b1);
   endtask

   task automatic test_reserved_mode();
      write_reg(coc_pkg::REG_MODE, coc_pkg::CSR_DATA_W'(coc_pkg::MODE_RESERVED));
      send_pixel(12'd7, 12'd7, 32'h5566_7788, 32'hFF00_0000, 1'b0, 1'b1);
      send_pixel(12'd40, 12'd7, 32'h5566_7788, 32'hFF00_0000, 1'b0, 1'b1);
   endtask

   task automatic test_clipping();
      configure(-5, -3, 64, 64, 40, 30, coc_pkg::MODE_MONO, 1'b1);
      send_pixel(12'd0, 12'd0, 32'h0F0F_0F0F, 32'h0, 1'b1, 1'b1);
      send_pixel(12'd38, 12'd28, 32'h0F0F_0F0F, 32'h0, 1'b1, 1'b1);
      send_pixel(12'd39, 12'd5, 32'h0F0F_0F0F, 32'h0, 1'b1, 1'b1);
      send_pixel(12'd5, 12'd29, 32'h0F0F_0F0F, 32'h0, 1'b1, 1'b1);
      // wholly off the top left
      configure(-64, -64, 64, 64, 4096, 4096, coc_pkg::MODE_MONO, 1'b1);
      send_pixel(12'd0, 12'd0, 32'h1111_1111, 32'h0, 1'b0, 1'b1);
      // at the far corner, beyond the last column
      configure(4095, 4095, 64, 64, 4096, 4096, coc_pkg::MODE_MONO, 1'b1);
      send_pixel(12'd4095, 12'd4095, 32'h2222_2222, 32'h0, 1'b0, 1'b1);
      // oversized registers saturate
      configure(4000, 0, 127, 127, 8191, 8191, coc_pkg::MODE_MONO, 1'b1);
      send_pixel(12'd4063, 12'd63, 32'h3333_3333, 32'h0, 1'b0, 1'b1);
      send_pixel(12'd4064, 12'd10, 32'h3333_3333, 32'h0, 1'b0, 1'b1);
      configure(4060, 0, 64, 64, 4096, 4096, coc_pkg::MODE_MONO, 1'b1);
      send_pixel(12'd4094, 12'd0, 32'h4444_4444, 32'h0, 1'b0, 1'b1);
      send_pixel(12'd4095, 12'd0, 32'h4444_4444, 32'h0, 1'b0, 1'b1);
      // zero-sized cursor, then zero and one pixel surfaces
      configure(0, 0, 0, 64, 1024, 768, coc_pkg::MODE_MONO, 1'b1);
      send_pixel(12'd0, 12'd0, 32'h5555_5555, 32'h0, 1'b0, 1'b1);
      configure(0, 0, 64, 64, 0, 1, coc_pkg::MODE_MONO, 1'b1);
      send_pixel(12'd0, 12'd0, 32'h6666_6666, 32'h0, 1'b0, 1'b1);
   endtask

   function automatic int pick_position();
      case ($urandom_range(9))
         0: return -int'($urandom_range(64, 1));
         1: return int'($urandom_range(8191)) - 4096;
         2: return 4095 - int'($urandom_range(70));
         3: return int'($urandom_range(4095));
         default: return int'($urandom_range(200)) - 64;
      endcase
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(9))
         0: return 0;
         1: return int'($urandom_range(127, 65));
         2: return 64;
         default: return int'($urandom_range(64, 1));
      endcase
   endfunction

   function automatic int pick_surface();
      case ($urandom_range(9))
         0: return 0;
         1: return int'($urandom_range(8191, 4097));
         2: return 4096;
         3: return int'($urandom_range(4, 1));
         default: return int'($urandom_range(300, 2));
      endcase
   endfunction

   // mostly around the clipped rectangle, sometimes anywhere
   function automatic int pick_coord(int pos, int len, int surf);
      int lo;
      int hi;
      int a;
      int b;
      if ($urandom_range(9) < 3) return int'($urandom_range(4095));
      lo = span_lo(pos);
      hi = span_hi(pos, len, surf);
      a = lo > 2 ? lo - 2 : 0;
      b = (hi > lo ? hi : lo) + 1;
      if (b > 4095) b = 4095;
      return int'($urandom_range(b, a));
   endfunction

   task automatic random_phase(int count, bit burst, bit hold);
      int x;
      int y;
      int w;
      int h;
      int sw;
      int sh;
      logic [31:0] cur;
      x = pick_position();
      y = pick_position();
      w = pick_dim();
      h = pick_dim();
      sw = pick_surface();
      sh = pick_surface();
      configure(x, y, w, h, sw, sh, coc_pkg::coc_mode_type'($urandom_range(3)),
                $urandom_range(9) != 0);
      full_rate = burst;
      for (int i = 0; i < count; i++) begin
         if (hold && i == count / 2)
            while (pending_pixels.size() != 0) @(negedge clock);
         cur = $urandom;
         case ($urandom_range(3))
            0: cur[31:24] = 8'h00;
            1: cur[31:24] = 8'hFF;
            default: ;
         endcase
         send_pixel(coc_pkg::PIX_W'(pick_coord(x, w, sw)),
                    coc_pkg::PIX_W'(pick_coord(y, h, sh)), $urandom, cur,
                    1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      full_rate = 1'b0;
   endtask

   task automatic test_random();
      for (int p = 0; p < 14; p++)
         random_phase(60, p == 5, p == 9);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_pass_through();
      test_monochrome();
      test_alpha_blend();
      test_masked_colour();
      test_reserved_mode();
      test_clipping();
      test_random();
      settle_pipeline();
      repeat (8) @(negedge clock);
      $display("covered %0d pixels, %0d inside the cursor, over %0d register settings;",
               n_items, n_hits, n_settings);
      $display("all modes, edge clipping and saturation, random stalls; %0d results checked",
               n_results);
      if (n_mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
